// File: hdl/assert_macros.svh
// Assertion macros shared by the rotator RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(name, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: hdl/fcpr_pkg.sv
// Shared constants, types and the quarter-wave sine table of the Clarke/Park rotator.
// No dependencies.
`default_nettype none

package fcpr_pkg;

  localparam int DATA_BITS        = 16;
  localparam int ANGLE_BITS       = 16;
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int TAB_BITS         = $clog2(SINE_TABLE_DEPTH);
  localparam int QUAD_SHIFT       = ANGLE_BITS - 2;
  localparam int ACC_BITS         = 2 * DATA_BITS;

  localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1) << QUAD_SHIFT;

  // 1/sqrt3 in Q16, kept signed for the multiplier
  localparam logic signed [17:0] INV_SQRT3_Q16 = 18'sd37837;
  localparam logic [63:0]        HALF_PI_Q30   = 64'd1686629713;
  localparam longint             SINE_PEAK     = 32767;

  typedef logic signed [DATA_BITS-1:0] sample_t;
  typedef logic signed [ACC_BITS-1:0]  acc_t;
  typedef logic [SINE_TABLE_DEPTH-1:0][DATA_BITS-1:0] sine_tab_t;

  typedef enum logic {
    OP_PARK     = 1'b0,
    OP_INV_PARK = 1'b1
  } op_t;

  localparam sample_t SINE_MAX = sample_t'(SINE_PEAK);

  // Q30 Taylor series up to x^11, truncating at each step, rounded to Q15
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t           tab;
    logic [63:0]         x;
    logic [63:0]         x2;
    logic [63:0]         term;
    logic signed [63:0]  sum;
    logic signed [63:0]  r;
    int                  k;
    tab = '0;
    for (k = 0; k < SINE_TABLE_DEPTH; k++) begin
      x    = (HALF_PI_Q30 * 64'(k)) >> TAB_BITS;
      x2   = (x * x) >> 30;
      term = ((x * x2) >> 30) / 64'd6;
      sum  = $signed(x) - $signed(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - $signed(term);
      if (sum < 0) begin
        sum = '0;
      end
      r = (sum * 64'(SINE_PEAK) + 64'sd536870912) >>> 30;
      if (r > 64'(SINE_PEAK)) begin
        r = 64'(SINE_PEAK);
      end
      tab[k] = r[DATA_BITS-1:0];
    end
    return tab;
  endfunction

  // entry for a quarter turn exactly is SINE_MAX and lives outside the table
  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

`default_nettype wire

// File: hdl/foc_clarke_park_rotator_unit.sv
// Clarke/Park and inverse Park rotator, Q1.15, five-stage pipeline.
// Depends on fcpr_pkg, fcpr_quarter_sine, fcpr_mac_cell and assert_macros.svh.
//
// Input channel in_*: in_tuser selects the operation (0: Clarke then Park on
// phase currents, 1: inverse Park on d/q voltages); in_tdata carries the two
// samples and the electrical angle (65536 steps per turn).
// Output channel out_*: alpha, beta, d and q in out_tdata, the clip flag in
// out_tuser. With operation 1, d and q echo the inputs.
// Throughput: one item per cycle while out_tready is high; the pipeline is five registered stages
// (table lookup and Clarke multiply, Clarke rounding, two chained MAC cells
// per output lane, rounding and saturation into the output register).
// Each stage has its own valid bit and advances when the stage ahead is empty
// or moving, so bubbles close up while the receiver stalls; in_tready drops
// only once all five stages hold items.
// Reset (rst_n low, synchronous) empties the pipeline; no item is lost or
// duplicated across a stall, and the output holds steady until taken.
`default_nettype none
`include "assert_macros.svh"

module foc_clarke_park_rotator_unit import fcpr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // in_a[15:0], in_b[31:16], angle[47:32]
  input  logic [0:0]  in_tuser,   // op[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // alpha_out[15:0], beta_out[31:16], d_out[47:32], q_out[63:48]
  output logic [0:0]  out_tuser   // saturated[0]
);

  localparam int SUM_BITS  = DATA_BITS + 2;
  localparam int PROD_BITS = SUM_BITS + $bits(INV_SQRT3_Q16);
  localparam int SAT_BITS  = DATA_BITS + 4;
  localparam int RND_BITS  = ACC_BITS + 1;
  localparam logic signed [SAT_BITS-1:0] SAT_HI = SAT_BITS'((2 ** (DATA_BITS - 1)) - 1);
  localparam logic signed [SAT_BITS-1:0] SAT_LO = -SAT_HI - SAT_BITS'(1);

  typedef struct packed {
    logic    clip;
    sample_t val;
  } sat_t;

  function automatic sat_t sat_word(input logic signed [SAT_BITS-1:0] v);
    sat_t s;
    if (v > SAT_HI) begin
      s.clip = 1'b1;
      s.val  = sample_t'(SAT_HI);
    end else if (v < SAT_LO) begin
      s.clip = 1'b1;
      s.val  = sample_t'(SAT_LO);
    end else begin
      s.clip = 1'b0;
      s.val  = v[DATA_BITS-1:0];
    end
    return s;
  endfunction

  // round-half-up to Q15 of a Q30 sum
  function automatic logic signed [SAT_BITS-1:0] round_q15(input acc_t v);
    logic signed [RND_BITS-1:0] w;
    w = RND_BITS'(v) + RND_BITS'(1 << 14);
    return SAT_BITS'(w >>> 15);
  endfunction

  // stage enables, from the output back
  logic en1, en2, en3, en4, en5;
  logic v1_r, v2_r, v3_r, v4_r, out_tvalid_r;

  assign en5 = !out_tvalid_r || out_tready;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      v4_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) out_tvalid_r <= v4_r;
    end
  end

  // ---- stage 1: table lookup, Clarke product
  sample_t                     in_a, in_b;
  logic [ANGLE_BITS-1:0]       in_angle;
  logic [ANGLE_BITS-1:0]       cos_angle;
  sample_t                     sin_nxt, cos_nxt;
  logic signed [SUM_BITS-1:0]  ab_sum;
  logic signed [PROD_BITS-1:0] bprod_nxt;

  assign in_a      = in_tdata[15:0];
  assign in_b      = in_tdata[31:16];
  assign in_angle  = in_tdata[47:32];
  assign cos_angle = in_angle + QUARTER_TURN;

  fcpr_quarter_sine u_sin (
    .angle_i (in_angle),
    .sine_o  (sin_nxt)
  );

  fcpr_quarter_sine u_cos (
    .angle_i (cos_angle),
    .sine_o  (cos_nxt)
  );

  assign ab_sum    = SUM_BITS'(in_a) + (SUM_BITS'(in_b) <<< 1);
  assign bprod_nxt = PROD_BITS'(ab_sum) * PROD_BITS'(INV_SQRT3_Q16);

  op_t                         op1_r;
  sample_t                     a1_r, b1_r, sin1_r, cos1_r;
  logic signed [PROD_BITS-1:0] bprod1_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      op1_r    <= op_t'(in_tuser[0]);
      a1_r     <= in_a;
      b1_r     <= in_b;
      sin1_r   <= sin_nxt;
      cos1_r   <= cos_nxt;
      bprod1_r <= bprod_nxt;
    end
  end

  // ---- stage 2: Clarke beta, rotation operands
  logic signed [PROD_BITS-1:0] brnd;
  sat_t                        beta_sat;
  sample_t                     sgn_sin;

  assign brnd     = bprod1_r + PROD_BITS'(1 << 15);
  assign beta_sat = sat_word(SAT_BITS'(brnd >>> 16));
  // inverse Park flips the sign of the sine terms
  assign sgn_sin  = (op1_r == OP_INV_PARK) ? -sin1_r : sin1_r;

  op_t     op2_r;
  sample_t a2_r, b2_r, y2_r, cos2_r, s2_r, ns2_r, beta2_r;
  logic    bclip2_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      op2_r    <= op1_r;
      a2_r     <= a1_r;
      b2_r     <= b1_r;
      y2_r     <= (op1_r == OP_INV_PARK) ? b1_r : beta_sat.val;
      cos2_r   <= cos1_r;
      s2_r     <= sgn_sin;
      ns2_r    <= -sgn_sin;
      beta2_r  <= beta_sat.val;
      bclip2_r <= beta_sat.clip;
    end
  end

  // ---- stages 3 and 4: two MAC cells per lane
  acc_t lane1_c3, lane2_c3, lane1_c4, lane2_c4;

  fcpr_mac_cell u_lane1_c3 (
    .clk    (clk),
    .en     (en3),
    .acc_in ('0),
    .mul_a  (a2_r),
    .mul_b  (cos2_r),
    .acc_o  (lane1_c3)
  );

  fcpr_mac_cell u_lane2_c3 (
    .clk    (clk),
    .en     (en3),
    .acc_in ('0),
    .mul_a  (y2_r),
    .mul_b  (cos2_r),
    .acc_o  (lane2_c3)
  );

  op_t     op3_r;
  sample_t a3_r, b3_r, y3_r, s3_r, ns3_r, beta3_r;
  logic    bclip3_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      op3_r    <= op2_r;
      a3_r     <= a2_r;
      b3_r     <= b2_r;
      y3_r     <= y2_r;
      s3_r     <= s2_r;
      ns3_r    <= ns2_r;
      beta3_r  <= beta2_r;
      bclip3_r <= bclip2_r;
    end
  end

  fcpr_mac_cell u_lane1_c4 (
    .clk    (clk),
    .en     (en4),
    .acc_in (lane1_c3),
    .mul_a  (y3_r),
    .mul_b  (s3_r),
    .acc_o  (lane1_c4)
  );

  fcpr_mac_cell u_lane2_c4 (
    .clk    (clk),
    .en     (en4),
    .acc_in (lane2_c3),
    .mul_a  (a3_r),
    .mul_b  (ns3_r),
    .acc_o  (lane2_c4)
  );

  op_t     op4_r;
  sample_t a4_r, b4_r, beta4_r;
  logic    bclip4_r;

  always_ff @(posedge clk) begin
    if (en4) begin
      op4_r    <= op3_r;
      a4_r     <= a3_r;
      b4_r     <= b3_r;
      beta4_r  <= beta3_r;
      bclip4_r <= bclip3_r;
    end
  end

  // ---- stage 5: rounding, saturation, output register
  sat_t        r1, r2;
  logic [63:0] out_tdata_nxt, out_tdata_r;
  logic        out_sat_nxt, out_sat_r;

  assign r1 = sat_word(round_q15(lane1_c4));
  assign r2 = sat_word(round_q15(lane2_c4));

  always_comb begin
    case (op4_r)
      OP_PARK: begin
        out_tdata_nxt = {r2.val, r1.val, beta4_r, a4_r};
        out_sat_nxt   = bclip4_r || r1.clip || r2.clip;
      end
      OP_INV_PARK: begin
        out_tdata_nxt = {b4_r, a4_r, r2.val, r1.val};
        out_sat_nxt   = r1.clip || r2.clip;
      end
      default: begin
        out_tdata_nxt = '0;
        out_sat_nxt   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      out_tdata_r <= out_tdata_nxt;
      out_sat_r   <= out_sat_nxt;
    end
  end

  assign in_tready  = en1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_sat_r;

  // ---- checks
  `ASSERT_IMPL(a_ready_when_empty_out, clk, rst_n, !out_tvalid_r, in_tready, "pipeline blocked with empty output")
  `ASSERT_NEXT(a_stage1_holds, clk, rst_n, v1_r && !en2, v1_r, "stage 1 item dropped under stall")
  `ASSERT_NEXT(a_last_stage_lands, clk, rst_n, v4_r && en5, out_tvalid_r, "MAC result lost at output")
  `ASSERT_IMPL(a_clip_at_rail, clk, rst_n, out_tvalid_r && out_sat_r, out_tdata_r[15:0] == 16'h7fff || out_tdata_r[15:0] == 16'h8000 || out_tdata_r[31:16] == 16'h7fff || out_tdata_r[31:16] == 16'h8000 || out_tdata_r[47:32] == 16'h7fff || out_tdata_r[47:32] == 16'h8000 || out_tdata_r[63:48] == 16'h7fff || out_tdata_r[63:48] == 16'h8000, "clip flag without a railed output")

endmodule

`default_nettype wire

// File: hdl/fcpr_quarter_sine.sv
// Sine of a 16-bit angle from the quarter-wave table, quadrant folding included.
// Depends on fcpr_pkg.
`default_nettype none

module fcpr_quarter_sine import fcpr_pkg::*; (
  input  logic [ANGLE_BITS-1:0] angle_i,
  output sample_t               sine_o
);

  logic [1:0]          quad;
  logic [TAB_BITS-1:0] idx;
  logic [TAB_BITS:0]   mir;
  sample_t             mag;

  assign quad = angle_i[ANGLE_BITS-1 -: 2];
  assign idx  = angle_i[QUAD_SHIFT-1 -: TAB_BITS];

  // odd quadrants run the table backwards; top bit set only at the peak
  assign mir = quad[0] ? ((TAB_BITS+1)'(SINE_TABLE_DEPTH) - {1'b0, idx}) : {1'b0, idx};
  assign mag = mir[TAB_BITS] ? SINE_MAX : sample_t'(SINE_TAB[mir[TAB_BITS-1:0]]);

  assign sine_o = quad[1] ? -mag : mag;

endmodule

`default_nettype wire

// File: hdl/fcpr_mac_cell.sv
// Multiply-accumulate cell: registers acc_in + mul_a * mul_b, chained to form a dot product.
// Depends on fcpr_pkg.
`default_nettype none

module fcpr_mac_cell import fcpr_pkg::*; (
  input  logic    clk,
  input  logic    en,
  input  acc_t    acc_in,
  input  sample_t mul_a,
  input  sample_t mul_b,
  output acc_t    acc_o
);

  acc_t prod;
  acc_t acc_nxt;
  acc_t acc_r;

  assign prod    = acc_t'(mul_a) * acc_t'(mul_b);
  assign acc_nxt = acc_in + prod;

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc_o = acc_r;

endmodule

`default_nettype wire
